[rtl/alpha_blend_sprite_blit_core_assert.svh]
// Assertion macros for the alpha blend sprite blit core.
// Taken in by the top level only; relies on clk_i and rst_ni in the including scope.
`ifndef ALPHA_BLEND_SPRITE_BLIT_CORE_ASSERT_SVH
`define ALPHA_BLEND_SPRITE_BLIT_CORE_ASSERT_SVH

// Checked on every rising clock edge, quiet while reset is held.
`define ABSB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ABSB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/absb_pkg.sv]
// Shared types, constants and register codes for the alpha blend sprite blit core.
// No dependencies.
package absb_pkg;

  // Largest sprite side in pixels; the raster counters are sized from it.
  localparam int unsigned MaxDim = 4096;
  localparam int unsigned CntW   = $clog2(MaxDim);

  // Fixed field widths.
  localparam int unsigned DimW   = 13;
  localparam int unsigned PosW   = 12;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned AddrW  = 24;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned CfgW   = 13;

  // Configuration register indexes.
  localparam logic [IdxW-1:0] RegDestWidth  = 3'd0;
  localparam logic [IdxW-1:0] RegDestHeight = 3'd1;
  localparam logic [IdxW-1:0] RegPosX       = 3'd2;
  localparam logic [IdxW-1:0] RegPosY       = 3'd3;
  localparam logic [IdxW-1:0] RegSrcWidth   = 3'd4;
  localparam logic [IdxW-1:0] RegSrcHeight  = 3'd5;

  typedef struct packed {
    logic [DimW-1:0] dest_width;
    logic [DimW-1:0] dest_height;
    logic [PosW-1:0] pos_x;
    logic [PosW-1:0] pos_y;
    logic [DimW-1:0] src_width;
    logic [DimW-1:0] src_height;
  } cfg_t;

  // Place of one sprite pixel within the sprite.
  typedef struct packed {
    logic [CntW-1:0] col;
    logic [CntW-1:0] row;
    logic            last;
  } pos_t;

  typedef struct packed {
    logic [ChanW-1:0] src_red;
    logic [ChanW-1:0] src_green;
    logic [ChanW-1:0] src_blue;
    logic [ChanW-1:0] src_alpha;
    logic [ChanW-1:0] dst_red;
    logic [ChanW-1:0] dst_green;
    logic [ChanW-1:0] dst_blue;
  } pix_t;

  typedef struct packed {
    logic [AddrW-1:0] dest_address;
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic             write_enable;
  } res_t;

endpackage

[rtl/absb_cfg_regs.sv]
// Configuration register file of the alpha blend sprite blit core.
// Depends on absb_pkg.
module absb_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [absb_pkg::IdxW-1:0]    cfg_index_i,
  input  logic [absb_pkg::CfgW-1:0]    cfg_wdata_i,
  output absb_pkg::cfg_t               cfg_o
);

  absb_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        absb_pkg::RegDestWidth:  cfg_d.dest_width  = cfg_wdata_i[absb_pkg::DimW-1:0];
        absb_pkg::RegDestHeight: cfg_d.dest_height = cfg_wdata_i[absb_pkg::DimW-1:0];
        absb_pkg::RegPosX:       cfg_d.pos_x       = cfg_wdata_i[absb_pkg::PosW-1:0];
        absb_pkg::RegPosY:       cfg_d.pos_y       = cfg_wdata_i[absb_pkg::PosW-1:0];
        absb_pkg::RegSrcWidth:   cfg_d.src_width   = cfg_wdata_i[absb_pkg::DimW-1:0];
        absb_pkg::RegSrcHeight:  cfg_d.src_height  = cfg_wdata_i[absb_pkg::DimW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dest_width  <= 13'd4096;
      cfg_q.dest_height <= 13'd4096;
      cfg_q.pos_x       <= '0;
      cfg_q.pos_y       <= '0;
      cfg_q.src_width   <= 13'd16;
      cfg_q.src_height  <= 13'd16;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/absb_raster_ctr.sv]
// Column and row counters that place each accepted sprite pixel.
// Depends on absb_pkg.
module absb_raster_ctr (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            advance_i,
  input  logic [absb_pkg::DimW-1:0]       src_width_i,
  input  logic [absb_pkg::DimW-1:0]       src_height_i,
  output absb_pkg::pos_t                  pos_o
);

  logic [absb_pkg::CntW-1:0] col_q, col_d;
  logic [absb_pkg::CntW-1:0] row_q, row_d;
  logic [absb_pkg::CntW-1:0] width_m1;
  logic [absb_pkg::CntW-1:0] height_m1;
  logic                      col_end;
  logic                      row_end;

  // Sprite side minus one, with zero treated as one and anything above the
  // maximum treated as the maximum.
  function automatic logic [absb_pkg::CntW-1:0] side_m1(input logic [absb_pkg::DimW-1:0] v);
    logic [absb_pkg::DimW-1:0] dec;
    dec = v - absb_pkg::DimW'(1);
    if (v == '0) begin
      side_m1 = '0;
    end else if (v > absb_pkg::DimW'(absb_pkg::MaxDim)) begin
      side_m1 = absb_pkg::CntW'(absb_pkg::MaxDim - 1);
    end else begin
      side_m1 = dec[absb_pkg::CntW-1:0];
    end
  endfunction

  assign width_m1  = side_m1(src_width_i);
  assign height_m1 = side_m1(src_height_i);
  // A counter at or past the end (possible after a size was lowered) wraps.
  assign col_end   = col_q >= width_m1;
  assign row_end   = row_q >= height_m1;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (advance_i) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + absb_pkg::CntW'(1);
      end else begin
        col_d = col_q + absb_pkg::CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign pos_o.col  = col_q;
  assign pos_o.row  = row_q;
  assign pos_o.last = col_end && row_end;

endmodule

[rtl/absb_pixel_calc.sv]
// Destination clipping, address generation and per-channel alpha blend.
// Purely combinational; depends on absb_pkg.
module absb_pixel_calc (
  input  absb_pkg::cfg_t  cfg_i,
  input  absb_pkg::pos_t  pos_i,
  input  absb_pkg::pix_t  pix_i,
  output absb_pkg::res_t  res_o
);

  localparam int unsigned ProdW = 2 * absb_pkg::DimW;

  logic [absb_pkg::DimW-1:0] dcol;
  logic [absb_pkg::DimW-1:0] drow;
  logic                      in_dest;
  logic [ProdW-1:0]          addr_full;

  // (dst * (256 - a) + src * a) >> 8; the sum never exceeds 16 bits.
  function automatic logic [absb_pkg::ChanW-1:0] blend(
    input logic [absb_pkg::ChanW-1:0] s,
    input logic [absb_pkg::ChanW-1:0] d,
    input logic [absb_pkg::ChanW-1:0] a
  );
    logic [absb_pkg::ChanW:0]     inv_a;
    logic [2*absb_pkg::ChanW:0]   sum;
    inv_a = 9'd256 - {1'b0, a};
    sum   = ({9'd0, d} * {8'd0, inv_a}) + ({9'd0, s} * {9'd0, a});
    blend = sum[2*absb_pkg::ChanW-1:absb_pkg::ChanW];
  endfunction

  // Positions stay below 8192, so 13 bits hold the sums.
  assign dcol    = {1'b0, cfg_i.pos_x} + {1'b0, pos_i.col};
  assign drow    = {1'b0, cfg_i.pos_y} + {1'b0, pos_i.row};
  assign in_dest = (dcol < cfg_i.dest_width) && (drow < cfg_i.dest_height);

  assign addr_full = ({{absb_pkg::DimW{1'b0}}, drow} * {{absb_pkg::DimW{1'b0}}, cfg_i.dest_width})
                   + {{absb_pkg::DimW{1'b0}}, dcol};

  always_comb begin
    res_o = '0;
    if (in_dest) begin
      res_o.dest_address = addr_full[absb_pkg::AddrW-1:0];
      res_o.out_red      = blend(pix_i.src_red,   pix_i.dst_red,   pix_i.src_alpha);
      res_o.out_green    = blend(pix_i.src_green, pix_i.dst_green, pix_i.src_alpha);
      res_o.out_blue     = blend(pix_i.src_blue,  pix_i.dst_blue,  pix_i.src_alpha);
      res_o.write_enable = 1'b1;
    end
  end

endmodule

[rtl/alpha_blend_sprite_blit_core.sv]
// Top level of the alpha blend sprite blit core.
// Depends on absb_pkg, absb_cfg_regs, absb_raster_ctr, absb_pixel_calc and the assert header.
//
// Usage: the sprite is fed one RGBA pixel per beat in raster order on the input
// channel (in_valid_i / in_stall_o), each beat also carrying the destination RGB
// pixel that lies under it. Every input beat produces exactly one output beat on
// the output channel (out_valid_o / out_stall_i) holding the destination address,
// the blended color, a write enable that is low for pixels clipped off the
// destination (all other fields are then zero), and a last flag on the final pixel.
// Flow: a beat accepted into the input stage goes through the clip, address
// multiply and blend logic and is registered in the output stage once that
// stage is free, where its result is offered until taken. With the output
// not stalled, throughput is one beat per cycle through the two-stage
// pipeline; the input stage accepts a new beat whenever it is empty or
// its contents move into the output stage, so the block keeps taking pixels while
// a finished result waits. A stall holds the output stage and, once both stages
// are full, raises in_stall_o in the same cycle.
// Reset clears both stages, the raster counters and loads the register defaults.
// Configuration writes are taken on any cycle but are meant for an idle block.
`include "alpha_blend_sprite_blit_core_assert.svh"

module alpha_blend_sprite_blit_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [absb_pkg::IdxW-1:0]           cfg_index_i,
  input  logic [absb_pkg::CfgW-1:0]           cfg_wdata_i,
  // Input channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [absb_pkg::ChanW-1:0]          src_red_i,
  input  logic [absb_pkg::ChanW-1:0]          src_green_i,
  input  logic [absb_pkg::ChanW-1:0]          src_blue_i,
  input  logic [absb_pkg::ChanW-1:0]          src_alpha_i,
  input  logic [absb_pkg::ChanW-1:0]          dst_red_i,
  input  logic [absb_pkg::ChanW-1:0]          dst_green_i,
  input  logic [absb_pkg::ChanW-1:0]          dst_blue_i,
  // Output channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [absb_pkg::AddrW-1:0]          dest_address_o,
  output logic [absb_pkg::ChanW-1:0]          out_red_o,
  output logic [absb_pkg::ChanW-1:0]          out_green_o,
  output logic [absb_pkg::ChanW-1:0]          out_blue_o,
  output logic                                write_enable_o,
  output logic                                last_o
);

  absb_pkg::cfg_t cfg;
  absb_pkg::pos_t pos_cur;
  absb_pkg::pix_t pix_in;
  absb_pkg::res_t res_calc;

  // Input stage.
  logic           s1_valid_q, s1_valid_d;
  absb_pkg::pix_t s1_pix_q;
  absb_pkg::pos_t s1_pos_q;

  // Output stage.
  logic           out_valid_q, out_valid_d;
  absb_pkg::res_t out_res_q;
  logic           out_last_q;

  logic out_ready;
  logic s1_ready;
  logic in_acc;
  logic s1_move;

  absb_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The counters step when a beat is accepted, so each beat carries its own place.
  absb_raster_ctr u_raster_ctr (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (in_acc),
    .src_width_i  (cfg.src_width),
    .src_height_i (cfg.src_height),
    .pos_o        (pos_cur)
  );

  absb_pixel_calc u_pixel_calc (
    .cfg_i (cfg),
    .pos_i (s1_pos_q),
    .pix_i (s1_pix_q),
    .res_o (res_calc)
  );

  assign pix_in.src_red   = src_red_i;
  assign pix_in.src_green = src_green_i;
  assign pix_in.src_blue  = src_blue_i;
  assign pix_in.src_alpha = src_alpha_i;
  assign pix_in.dst_red   = dst_red_i;
  assign pix_in.dst_green = dst_green_i;
  assign pix_in.dst_blue  = dst_blue_i;

  // Handshake: the output stage frees up when empty or its beat is taken, and
  // the input stage frees up when empty or its beat moves forward.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || out_ready;
  assign in_acc     = in_valid_i && s1_ready;
  assign s1_move    = s1_valid_q && out_ready;
  assign in_stall_o = !s1_ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (out_ready) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_ready ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q <= pix_in;
      s1_pos_q <= pos_cur;
    end
    if (s1_move) begin
      out_res_q  <= res_calc;
      out_last_q <= s1_pos_q.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign dest_address_o = out_res_q.dest_address;
  assign out_red_o      = out_res_q.out_red;
  assign out_green_o    = out_res_q.out_green;
  assign out_blue_o     = out_res_q.out_blue;
  assign write_enable_o = out_res_q.write_enable;
  assign last_o         = out_last_q;

  // The input side only stalls when both pipeline stages hold a beat.
  `ABSB_ASSERT(a_stall_only_when_full, in_stall_o |-> (s1_valid_q && out_valid_q), "input stalled with a free stage")

  // A clipped pixel leaves every payload field at zero.
  `ABSB_ASSERT(a_clipped_zero, (out_valid_o && !write_enable_o) |-> (dest_address_o == '0 && out_red_o == '0 && out_green_o == '0 && out_blue_o == '0), "clipped pixel carries data")

  // After the final sprite pixel is accepted the raster restarts at the origin.
  `ABSB_ASSERT(a_raster_restart, (in_acc && pos_cur.last) |=> (pos_cur.col == '0 && pos_cur.row == '0), "raster did not restart after last pixel")

  // Nothing can be in flight in the cycle after reset is seen.
  `ABSB_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> (!s1_valid_q && !out_valid_q), "pipeline not empty in reset")

endmodule

[sim/blit_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the alpha blend sprite blit core: tracks the raster position and
// register file, predicts every output beat and compares it. Depends on absb_pkg.
module blit_checker
  import absb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]  cfg_wdata_i,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  pix_t             pixel_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  res_t             result_i,
  input  logic             last_i,
  output int               errors_o,
  output int               pending_o,
  output int               results_o,
  output int               writes_o,
  output int               lasts_o
);

  typedef struct packed {
    res_t pix;
    logic last;
  } blit_result_t;

  blit_result_t    blended_q[$];
  blit_result_t    got;
  blit_result_t    want;
  cfg_t            regs;
  logic [CntW-1:0] col_pos;
  logic [CntW-1:0] row_pos;
  int              mismatches;
  int              results;
  int              writes;
  int              lasts;

  function automatic int unsigned clamp_side(logic [DimW-1:0] v);
    if (v == 0) return 1;
    if (v > MaxDim) return MaxDim;
    return 32'(v);
  endfunction

  function automatic logic [ChanW-1:0] mix_channel(logic [ChanW-1:0] s, logic [ChanW-1:0] d,
                                                   logic [ChanW-1:0] a);
    int unsigned acc;
    acc = (int'(d) * (256 - int'(a)) + int'(s) * int'(a)) >> 8;
    return acc[ChanW-1:0];
  endfunction

  // Works out the beat that the given pixel must produce, then steps the raster.
  task automatic blend_pixel(input pix_t p);
    int unsigned       sw;
    int unsigned       sh;
    int unsigned       dcol;
    int unsigned       drow;
    logic              col_end;
    logic              row_end;
    longint unsigned   lin;
    blit_result_t      e;
    sw      = clamp_side(regs.src_width);
    sh      = clamp_side(regs.src_height);
    col_end = (col_pos >= sw - 1);
    row_end = (row_pos >= sh - 1);
    dcol    = int'(regs.pos_x) + int'(col_pos);
    drow    = int'(regs.pos_y) + int'(row_pos);
    e       = '0;
    if (dcol < regs.dest_width && drow < regs.dest_height) begin
      lin = longint'(drow) * longint'(regs.dest_width) + longint'(dcol);
      e.pix.dest_address = lin[AddrW-1:0];
      e.pix.out_red      = mix_channel(p.src_red, p.dst_red, p.src_alpha);
      e.pix.out_green    = mix_channel(p.src_green, p.dst_green, p.src_alpha);
      e.pix.out_blue     = mix_channel(p.src_blue, p.dst_blue, p.src_alpha);
      e.pix.write_enable = 1'b1;
    end
    e.last = col_end && row_end;
    blended_q.push_back(e);
    if (col_end) begin
      col_pos = '0;
      row_pos = row_end ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blended_q.delete();
      regs.dest_width  = DimW'(MaxDim);
      regs.dest_height = DimW'(MaxDim);
      regs.pos_x       = '0;
      regs.pos_y       = '0;
      regs.src_width   = DimW'(16);
      regs.src_height  = DimW'(16);
      col_pos          = '0;
      row_pos          = '0;
      mismatches       = 0;
      results          = 0;
      writes           = 0;
      lasts            = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        blend_pixel(pixel_i);
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegDestWidth:  regs.dest_width  = cfg_wdata_i[DimW-1:0];
          RegDestHeight: regs.dest_height = cfg_wdata_i[DimW-1:0];
          RegPosX:       regs.pos_x       = cfg_wdata_i[PosW-1:0];
          RegPosY:       regs.pos_y       = cfg_wdata_i[PosW-1:0];
          RegSrcWidth:   regs.src_width   = cfg_wdata_i[DimW-1:0];
          RegSrcHeight:  regs.src_height  = cfg_wdata_i[DimW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        got.pix  = result_i;
        got.last = last_i;
        results++;
        if (got.pix.write_enable === 1'b1) writes++;
        if (got.last === 1'b1) lasts++;
        if (blended_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("beat %0d arrived with no pixel outstanding: address %h rgb %h %h %h",
                     results, got.pix.dest_address, got.pix.out_red, got.pix.out_green,
                     got.pix.out_blue);
          end
        end else begin
          want = blended_q.pop_front();
          if (got.pix.dest_address !== want.pix.dest_address ||
              got.pix.out_red !== want.pix.out_red ||
              got.pix.out_green !== want.pix.out_green ||
              got.pix.out_blue !== want.pix.out_blue ||
              got.pix.write_enable !== want.pix.write_enable ||
              got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("beat %0d (expected/actual): address %h/%h red %h/%h green %h/%h",
                       results, want.pix.dest_address, got.pix.dest_address,
                       want.pix.out_red, got.pix.out_red, want.pix.out_green,
                       got.pix.out_green);
              $display("  blue %h/%h write %b/%b last %b/%b", want.pix.out_blue,
                       got.pix.out_blue, want.pix.write_enable, got.pix.write_enable,
                       want.last, got.last);
            end
          end
        end
      end
    end
    errors_o  <= mismatches;
    pending_o <= blended_q.size();
    results_o <= results;
    writes_o  <= writes;
    lasts_o   <= lasts;
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// Top of the sprite blit testbench: clock, reset, register writes and pixel stimulus.
// Depends on absb_pkg, alpha_blend_sprite_blit_core and blit_checker.
module testbench;
  import absb_pkg::*;

  // Random pixel count after the directed part, the stretch at the end that runs
  // without any gaps or stalls, and the cycle count at which the run is abandoned.
  localparam int RandomPixels = 1950;
  localparam int QuietTail    = 350;
  localparam int CycleLimit   = 300000;

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [IdxW-1:0]  cfg_index = '0;
  logic [CfgW-1:0]  cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  pix_t             pixel     = '0;
  logic             out_stall = 1'b0;
  logic             in_stall;
  logic             out_valid;
  logic [AddrW-1:0] dest_address;
  logic [ChanW-1:0] out_red;
  logic [ChanW-1:0] out_green;
  logic [ChanW-1:0] out_blue;
  logic             write_enable;
  logic             last;

  bit               gaps_on    = 1'b1;
  int               burst_left = 0;
  int               pixels_sent;
  int               settings;
  int               errors;
  int               pending;
  int               results;
  int               writes;
  int               lasts;

  alpha_blend_sprite_blit_core uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .src_red_i      (pixel.src_red),
    .src_green_i    (pixel.src_green),
    .src_blue_i     (pixel.src_blue),
    .src_alpha_i    (pixel.src_alpha),
    .dst_red_i      (pixel.dst_red),
    .dst_green_i    (pixel.dst_green),
    .dst_blue_i     (pixel.dst_blue),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .dest_address_o (dest_address),
    .out_red_o      (out_red),
    .out_green_o    (out_green),
    .out_blue_o     (out_blue),
    .write_enable_o (write_enable),
    .last_o         (last)
  );

  // The checker sees both channels and the register port exactly as the block does
  // and reports its mismatch, outstanding-beat, result, write and sprite-end counts back up here.
  blit_checker scoreboard (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .pixel_i     (pixel),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .result_i    ({dest_address, out_red, out_green, out_blue, write_enable}),
    .last_i      (last),
    .errors_o    (errors),
    .pending_o   (pending),
    .results_o   (results),
    .writes_o    (writes),
    .lasts_o     (lasts)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net: a hung handshake or a lost beat ends the run here.
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // Output back-pressure comes in bursts of random length. With gaps turned
  // off the stall drops as soon as the current burst has run out.
  always @(posedge clk) begin
    if (burst_left != 0) begin
      out_stall  <= 1'b1;
      burst_left <= burst_left - 1;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      burst_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Channel values favor the two extremes so that alpha 0 and alpha 255 and
  // saturated colors turn up often among the random pixels.
  function automatic logic [ChanW-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return ChanW'($urandom_range(0, 255));
    endcase
  endfunction

  // Destination sizes are mostly small so that sprites straddle the edges, with
  // zero, the nominal maximum, the largest 13-bit value and random values mixed in.
  function automatic logic [DimW-1:0] pick_dim(int unsigned typical_max);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return DimW'(MaxDim);
      3:       return DimW'($urandom_range(0, (1 << DimW) - 1));
      default: return DimW'($urandom_range(1, typical_max));
    endcase
  endfunction

  function automatic logic [PosW-1:0] pick_pos();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return PosW'($urandom_range(0, (1 << PosW) - 1));
      default: return PosW'($urandom_range(0, 40));
    endcase
  endfunction

  // Offers one pixel beat, sometimes after a short gap, and holds it until taken.
  // Within this task valid is only lowered for a gap, never in the step where it is raised.
  task automatic send_pixel(input pix_t p);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    pixel    <= p;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
  endtask

  task automatic send_random_pixels(input int count);
    pix_t p;
    repeat (count) begin
      p.src_red   = rand_chan();
      p.src_green = rand_chan();
      p.src_blue  = rand_chan();
      p.src_alpha = rand_chan();
      p.dst_red   = rand_chan();
      p.dst_green = rand_chan();
      p.dst_blue  = rand_chan();
      send_pixel(p);
    end
  endtask

  // Stops offering pixels and waits until every beat in flight has come out. The
  // first edge lets the checker's count catch up with the beat just accepted, and
  // the trailing edges cover the two-stage pipeline before anything else happens.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Registers are only rewritten with the block idle. The raster counters are
  // not cleared by a write, so a sprite may resume in the middle under new sizes.
  task automatic load_config(input cfg_t c);
    drain();
    write_reg(RegDestWidth, c.dest_width);
    write_reg(RegDestHeight, c.dest_height);
    write_reg(RegPosX, CfgW'(c.pos_x));
    write_reg(RegPosY, CfgW'(c.pos_y));
    write_reg(RegSrcWidth, c.src_width);
    write_reg(RegSrcHeight, c.src_height);
    cfg_we <= 1'b0;
    settings++;
  endtask

  initial begin
    cfg_t c;
    int   random_sent;
    int   count;
    random_sent = 0;
    pixels_sent = 0;
    settings    = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: a 16 by 16 sprite at the origin of a 4096 square image.
    // Transparent, opaque, half-covered, all-zero and all-one pixels.
    send_pixel({8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h12, 8'h34, 8'h56});
    send_pixel({8'h80, 8'h40, 8'hC0, 8'hFF, 8'hFF, 8'h00, 8'hFF});
    send_pixel({8'h00, 8'hFF, 8'hAA, 8'h80, 8'hFF, 8'h00, 8'h55});
    send_pixel('0);
    send_pixel('1);

    // One-pixel destination and zero sprite sizes, which act as one by one. The
    // column counter is left beyond the new width, so the first beat must close
    // the sprite, clipped, and the following ones land on address zero.
    load_config({13'd1, 13'd1, 12'd0, 12'd0, 13'd0, 13'd0});
    send_random_pixels(3);

    // Zero destination width: nothing can be written, the sprite end still shows.
    load_config({13'd0, 13'h1FFF, 12'd0, 12'd0, 13'd2, 13'd2});
    send_random_pixels(4);

    // Far corner of an oversized destination: the address wraps past 24 bits.
    load_config({13'h1FFF, 13'h1FFF, 12'hFFF, 12'hFFF, 13'd2, 13'd2});
    send_random_pixels(4);

    // Sprite sizes above the maximum clamp to it; the row crosses the right edge.
    load_config({13'd4096, 13'd4096, 12'd4090, 12'd4000, 13'h1FFF, 13'h1FFF});
    send_random_pixels(8);

    // Random register settings, each followed by a short run of pixels. Most
    // sprites are a few pixels on a side so that many of them complete, while the
    // occasional huge or zero size leaves the raster counters past the end.
    while (random_sent < RandomPixels) begin
      gaps_on <= (random_sent < RandomPixels - QuietTail) && ($urandom_range(0, 3) != 0);
      c.dest_width  = pick_dim(48);
      c.dest_height = pick_dim(48);
      c.pos_x       = pick_pos();
      c.pos_y       = pick_pos();
      c.src_width   = ($urandom_range(0, 7) == 0) ? pick_dim(8) : DimW'($urandom_range(1, 8));
      c.src_height  = ($urandom_range(0, 7) == 0) ? pick_dim(8) : DimW'($urandom_range(1, 8));
      load_config(c);
      count = $urandom_range(1, 40);
      send_random_pixels(count);
      random_sent += count;
    end

    drain();
    $display("Blended %0d pixel beats under %0d register settings after the reset defaults.",
             pixels_sent, settings);
    $display("%0d beats came out: %0d written, %0d clipped, %0d sprite ends, %0d mismatches.",
             results, writes, results - writes, lasts, errors);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
